>>> src/dic_pkg.sv
`default_nettype none

package dic_pkg;

	localparam int MAX_INTERVALS = 32;
	localparam int VALUE_BITS    = 16;
	localparam int FIELD_W       = 16;
	localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;

	typedef struct packed {
		value_t lo;
		value_t hi;
	} entry_t;

	typedef enum logic [2:0] {
		ST_COVERED  = 3'd0,
		ST_NEW      = 3'd1,
		ST_UP       = 3'd2,
		ST_DOWN     = 3'd3,
		ST_MERGED   = 3'd4,
		ST_FULL     = 3'd5,
		ST_INTERVAL = 3'd6,
		ST_EMPTY    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		K_COVER = 3'd0,
		K_NEW   = 3'd1,
		K_UP    = 3'd2,
		K_DOWN  = 3'd3,
		K_MERGE = 3'd4,
		K_FULL  = 3'd5
	} kind_t;

	typedef struct packed {
		logic  reach;
		kind_t kind;
	} cls_t;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_LIST = 1'b1;

endpackage

`default_nettype wire

>>> src/disjoint_interval_coalescer.sv
`default_nettype none

// Keeps up to MAX_INTERVALS sorted, disjoint, non-adjacent intervals in a single-port-read
// table memory and walks it one entry per cycle, a list walk only while the output is free.
// An add searches the entries in order, then decides, then moves entries when an interval
// opens or two merge, then writes a new interval after a move, and then emits its result.
// A list gives one result per cycle while the output is not stalled, or a single empty
// result when the table is empty. The input is taken only when the sequencer is idle;
// a finished result may still wait in the output register. No clearing pass runs after
// reset; only entries below the count are read.
module disjoint_interval_coalescer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [dic_pkg::FIELD_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [dic_pkg::FIELD_W-1:0]   range_low,
	output logic [dic_pkg::FIELD_W-1:0]   range_high,
	output logic                          last_result
);
	import dic_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SRCH   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_SHL    = 8'b0000_1000,
		S_SHR    = 8'b0001_0000,
		S_INS    = 8'b0010_0000,
		S_LIST   = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	entry_t  mem [MAX_INTERVALS];
	entry_t  rd_q;
	logic    rd_en;
	idx_t    rd_addr;
	logic    wr_en;
	idx_t    wr_addr;
	entry_t  wr_data;

	state_t  state_q;
	cnt_t    count_q;
	cnt_t    ptr_q;
	cnt_t    i_q;
	cnt_t    src_q;
	value_t  v_q;
	entry_t  prev_q;
	status_t pend_st_q;
	value_t  pend_lo_q;
	value_t  pend_hi_q;

	logic    out_valid_q;
	status_t out_st_q;
	value_t  out_lo_q;
	value_t  out_hi_q;
	logic    out_last_q;

	logic    out_free;
	logic    out_load;
	logic    has_prev;
	logic    has_cur;
	logic    full;
	cls_t    cls;
	cnt_t    ptr_nx;
	cnt_t    i_nx;
	cnt_t    src_nx;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_LIST) || (state_q == S_EMIT)) && out_free;
	assign has_prev  = (i_q != '0);
	assign has_cur   = (i_q < count_q);
	assign full      = (count_q == CNT_W'(MAX_INTERVALS));
	assign ptr_nx    = ptr_q + 1'b1;
	assign i_nx      = i_q + 1'b1;
	assign src_nx    = src_q + 1'b1;

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign range_low   = FIELD_W'(out_lo_q);
	assign range_high  = FIELD_W'(out_hi_q);
	assign last_result = out_last_q;

	dic_classify u_classify (
		.v        (v_q),
		.prev     (prev_q),
		.cur      (rd_q),
		.has_prev (has_prev),
		.has_cur  (has_cur),
		.full     (full),
		.cls      (cls)
	);

	// table port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && count_q != '0) begin
					rd_en = 1'b1;
				end
			end
			S_SRCH: begin
				if (!cls.reach && ptr_nx != count_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_nx[IDX_W-1:0];
				end
			end
			S_DECIDE: begin
				case (cls.kind)
					K_MERGE: begin
						wr_en   = 1'b1;
						wr_addr = IDX_W'(i_q - 1'b1);
						wr_data = '{lo: prev_q.lo, hi: rd_q.hi};
						if (i_nx < count_q) begin
							rd_en   = 1'b1;
							rd_addr = i_nx[IDX_W-1:0];
						end
					end
					K_UP: begin
						wr_en   = 1'b1;
						wr_addr = IDX_W'(i_q - 1'b1);
						wr_data = '{lo: prev_q.lo, hi: v_q};
					end
					K_DOWN: begin
						wr_en   = 1'b1;
						wr_addr = i_q[IDX_W-1:0];
						wr_data = '{lo: v_q, hi: rd_q.hi};
					end
					K_NEW: begin
						if (count_q > i_q) begin
							rd_en   = 1'b1;
							rd_addr = IDX_W'(count_q - 1'b1);
						end else begin
							wr_en   = 1'b1;
							wr_addr = i_q[IDX_W-1:0];
							wr_data = '{lo: v_q, hi: v_q};
						end
					end
					default: begin
					end
				endcase
			end
			S_SHL: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(src_q - 1'b1);
				if (src_nx < count_q) begin
					rd_en   = 1'b1;
					rd_addr = src_nx[IDX_W-1:0];
				end
			end
			S_SHR: begin
				wr_en   = 1'b1;
				wr_addr = src_nx[IDX_W-1:0];
				if (src_q > i_q) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(src_q - 1'b1);
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = i_q[IDX_W-1:0];
				wr_data = '{lo: v_q, hi: v_q};
			end
			S_LIST: begin
				if (out_free && ptr_nx != count_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_nx[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			i_q         <= '0;
			src_q       <= '0;
			v_q         <= '0;
			prev_q      <= '0;
			pend_st_q   <= ST_EMPTY;
			pend_lo_q   <= '0;
			pend_hi_q   <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= ST_EMPTY;
			out_lo_q    <= '0;
			out_hi_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ptr_q <= '0;
						i_q   <= '0;
						v_q   <= VALUE_BITS'(value);
						if (operation == OP_LIST) begin
							if (count_q == '0) begin
								pend_st_q <= ST_EMPTY;
								pend_lo_q <= '0;
								pend_hi_q <= '0;
								state_q   <= S_EMIT;
							end else begin
								state_q <= S_LIST;
							end
						end else if (count_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (cls.reach) begin
						i_q     <= ptr_q;
						state_q <= S_DECIDE;
					end else begin
						prev_q <= rd_q;
						if (ptr_nx == count_q) begin
							i_q     <= count_q;
							state_q <= S_DECIDE;
						end else begin
							ptr_q <= ptr_nx;
						end
					end
				end
				S_DECIDE: begin
					case (cls.kind)
						K_COVER: begin
							pend_st_q <= ST_COVERED;
							pend_lo_q <= rd_q.lo;
							pend_hi_q <= rd_q.hi;
							state_q   <= S_EMIT;
						end
						K_MERGE: begin
							pend_st_q <= ST_MERGED;
							pend_lo_q <= prev_q.lo;
							pend_hi_q <= rd_q.hi;
							if (i_nx < count_q) begin
								src_q   <= i_nx;
								state_q <= S_SHL;
							end else begin
								count_q <= count_q - 1'b1;
								state_q <= S_EMIT;
							end
						end
						K_UP: begin
							pend_st_q <= ST_UP;
							pend_lo_q <= prev_q.lo;
							pend_hi_q <= v_q;
							state_q   <= S_EMIT;
						end
						K_DOWN: begin
							pend_st_q <= ST_DOWN;
							pend_lo_q <= v_q;
							pend_hi_q <= rd_q.hi;
							state_q   <= S_EMIT;
						end
						K_FULL: begin
							pend_st_q <= ST_FULL;
							pend_lo_q <= v_q;
							pend_hi_q <= v_q;
							state_q   <= S_EMIT;
						end
						default: begin
							pend_st_q <= ST_NEW;
							pend_lo_q <= v_q;
							pend_hi_q <= v_q;
							if (count_q > i_q) begin
								src_q   <= count_q - 1'b1;
								state_q <= S_SHR;
							end else begin
								count_q <= count_q + 1'b1;
								state_q <= S_EMIT;
							end
						end
					endcase
				end
				S_SHL: begin
					if (src_nx < count_q) begin
						src_q <= src_nx;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_SHR: begin
					if (src_q > i_q) begin
						src_q <= src_q - 1'b1;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= S_EMIT;
				end
				S_LIST: begin
					if (out_free) begin
						out_st_q    <= ST_INTERVAL;
						out_lo_q    <= rd_q.lo;
						out_hi_q    <= rd_q.hi;
						out_last_q  <= (ptr_nx == count_q);
						if (ptr_nx == count_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_nx;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_st_q    <= pend_st_q;
						out_lo_q    <= pend_lo_q;
						out_hi_q    <= pend_hi_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_INTERVALS))
		else $error("interval count above table size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer did not leave idle after a transaction");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, wr_addr} <= {1'b0, count_q}))
		else $error("table write beyond occupied entries");

	a_partial_list: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (state_q == S_LIST))
		else $error("non-final result outside a list walk");

endmodule

`default_nettype wire

>>> src/dic_classify.sv
`default_nettype none

module dic_classify (
	input  dic_pkg::value_t v,
	input  dic_pkg::entry_t prev,
	input  dic_pkg::entry_t cur,
	input  logic            has_prev,
	input  logic            has_cur,
	input  logic            full,
	output dic_pkg::cls_t   cls
);
	import dic_pkg::*;

	logic covered;
	logic join_low;
	logic join_high;

	always_comb begin
		covered   = has_cur && (cur.lo <= v);
		join_low  = has_prev && (({1'b0, prev.hi} + 1'b1) == {1'b0, v});
		join_high = has_cur && (v != '1) && ({1'b0, cur.lo} == ({1'b0, v} + 1'b1));
		cls.reach = (cur.hi >= v);
		if (covered) begin
			cls.kind = K_COVER;
		end else if (join_low && join_high) begin
			cls.kind = K_MERGE;
		end else if (join_low) begin
			cls.kind = K_UP;
		end else if (join_high) begin
			cls.kind = K_DOWN;
		end else if (full) begin
			cls.kind = K_FULL;
		end else begin
			cls.kind = K_NEW;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dic_pkg::*;

	localparam int STUCK_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 2 * MAX_INTERVALS + 40;

	typedef struct {
		status_t          st;
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic             last;
	} interval_report_t;

	class interval_tracker;
		value_t           iv_lo [MAX_INTERVALS];
		value_t           iv_hi [MAX_INTERVALS];
		int               iv_count;
		interval_report_t pending_reports[$];
		int               errors;

		function new();
			iv_count = 0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100) begin
				$display("tb: mismatch at %0t: %s", $realtime, msg);
			end
		endtask

		function void push_report(status_t st, value_t lo, value_t hi, logic last);
			interval_report_t r;
			r.st = st;
			r.lo = FIELD_W'(lo);
			r.hi = FIELD_W'(hi);
			r.last = last;
			pending_reports.insert(pending_reports.size(), r);
		endfunction

		// updates the interval table and queues the expected results for one accepted transaction
		function void apply_item(logic op, value_t v);
			int   i;
			int   j;
			int   n;
			logic join_low;
			logic join_high;
			n = iv_count;
			if (op == OP_LIST) begin
				if (n == 0) begin
					push_report(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (i = 0; i < n; i++) begin
						push_report(ST_INTERVAL, iv_lo[i], iv_hi[i], i == n - 1);
					end
				end
				return;
			end
			i = 0;
			while (i < n && iv_hi[i] < v) i++;
			if (i < n && iv_lo[i] <= v) begin
				push_report(ST_COVERED, iv_lo[i], iv_hi[i], 1'b1);
				return;
			end
			join_low = (i > 0) && ({1'b0, iv_hi[i-1]} + 1 == {1'b0, v});
			join_high = (i < n) && ({1'b0, iv_lo[i]} == {1'b0, v} + 1);
			if (join_low && join_high) begin
				iv_hi[i-1] = iv_hi[i];
				for (j = i; j + 1 < n; j++) begin
					iv_lo[j] = iv_lo[j+1];
					iv_hi[j] = iv_hi[j+1];
				end
				iv_count = n - 1;
				push_report(ST_MERGED, iv_lo[i-1], iv_hi[i-1], 1'b1);
			end else if (join_low) begin
				iv_hi[i-1] = v;
				push_report(ST_UP, iv_lo[i-1], v, 1'b1);
			end else if (join_high) begin
				iv_lo[i] = v;
				push_report(ST_DOWN, v, iv_hi[i], 1'b1);
			end else if (n >= MAX_INTERVALS) begin
				push_report(ST_FULL, v, v, 1'b1);
			end else begin
				for (j = n; j > i; j--) begin
					iv_lo[j] = iv_lo[j-1];
					iv_hi[j] = iv_hi[j-1];
				end
				iv_lo[i] = v;
				iv_hi[i] = v;
				iv_count = n + 1;
				push_report(ST_NEW, v, v, 1'b1);
			end
		endfunction

		task check_report(logic [2:0] st, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
				logic last);
			interval_report_t exp_r;
			if (pending_reports.size() == 0) begin
				report($sformatf("unexpected result status %0d [%0d,%0d] last %0b",
					st, lo, hi, last));
				return;
			end
			exp_r = pending_reports.pop_front();
			if (st !== exp_r.st) begin
				report($sformatf("status %0d, expected %0d", st, exp_r.st));
			end
			if (lo !== exp_r.lo) begin
				report($sformatf("range_low %0d, expected %0d", lo, exp_r.lo));
			end
			if (hi !== exp_r.hi) begin
				report($sformatf("range_high %0d, expected %0d", hi, exp_r.hi));
			end
			if (last !== exp_r.last) begin
				report($sformatf("last_result %0b, expected %0b", last, exp_r.last));
			end
		endtask

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                operation = OP_ADD;
	logic [FIELD_W-1:0]  value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          status;
	logic [FIELD_W-1:0]  range_low;
	logic [FIELD_W-1:0]  range_high;
	logic                last_result;

	logic                quiet = 1'b0;
	logic                hold_req = 1'b0;
	logic                hold_done = 1'b0;
	int                  hold_left = 0;
	int                  stuck_cycles = 0;

	interval_tracker     sb = new();

	disjoint_interval_coalescer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.range_low  (range_low),
		.range_high (range_high),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.apply_item(operation, value[VALUE_BITS-1:0]);
			end
			if (out_valid && !out_stall) begin
				sb.check_report(status, range_low, range_high, last_result);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 23);
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	task send_item(logic op, logic [FIELD_W-1:0] v);
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!quiet) begin
			while ($urandom_range(99) < 23) begin
				in_valid <= 1'b0;
				value <= FIELD_W'($urandom);
				@(posedge clk);
			end
		end
	endtask

	task add_value(logic [FIELD_W-1:0] v);
		send_item(OP_ADD, v);
	endtask

	task send_mixed();
		int                 r;
		int                 k;
		logic [FIELD_W-1:0] v;
		r = $urandom_range(99);
		if (r < 10) begin
			send_item(OP_LIST, FIELD_W'($urandom));
			return;
		end
		if (r < 30 || sb.iv_count == 0) begin
			v = FIELD_W'($urandom_range(65535));
		end else if (r < 60) begin
			v = FIELD_W'(1000 + $urandom_range(63));
		end else if (r < 90) begin
			k = $urandom_range(sb.iv_count - 1);
			case ($urandom_range(3))
				0: v = sb.iv_lo[k] - 1'b1;
				1: v = sb.iv_hi[k] + 1'b1;
				2: v = sb.iv_lo[k];
				default: v = sb.iv_hi[k];
			endcase
		end else begin
			case ($urandom_range(3))
				0: v = '0;
				1: v = FIELD_W'(1);
				2: v = '1 - 1'b1;
				default: v = '1;
			endcase
		end
		add_value(v);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, edges of the value range, every add outcome but a full table
		send_item(OP_LIST, '0);
		add_value(16'd0);
		add_value(16'd0);
		add_value(16'hFFFF);
		add_value(16'hFFFE);
		add_value(16'hFFFF);
		add_value(16'd1);
		add_value(16'd3);
		add_value(16'd2);
		add_value(16'd5);
		add_value(16'd7);
		add_value(16'd6);
		add_value(16'hFFFC);
		add_value(16'hFFFD);
		add_value(16'd100);
		add_value(16'd99);
		add_value(16'd101);
		add_value(16'h5555);
		add_value(16'hAAAA);
		send_item(OP_LIST, '1);

		// fill the table past capacity with scattered values
		repeat (45) begin
			if ($urandom_range(3) == 0) begin
				add_value(FIELD_W'(1000 + $urandom_range(63)));
			end else begin
				add_value(FIELD_W'($urandom_range(65535)));
			end
		end
		send_item(OP_LIST, '0);

		quiet <= 1'b1;
		repeat (30) send_mixed();
		quiet <= 1'b0;

		hold_req <= 1'b1;
		repeat (24) send_mixed();
		send_item(OP_LIST, '0);
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

>>> disjoint_interval_coalescer.f
src/dic_pkg.sv
src/dic_classify.sv
src/disjoint_interval_coalescer.sv
tb/sv/tb.sv
